// ===== rtl/core/edr_pkg.sv =====
// ============================================================================
// Edit distance row engine package
// Operation codes, output width and the broadcast control word of the cells.
// ============================================================================
package edr_pkg;

    // Default longest string
    localparam int unsigned MAX_LEN_DEF = 64;

    // Width of the result fields
    localparam int unsigned OUT_W = 8;

    // Operation codes of an input word
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STEP   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Control broadcast to every cell for one row update
    typedef struct packed {
        logic       first_row;
        logic       sub_two;
        logic [7:0] ch;
    } ctrl_t;

endpackage

// ===== rtl/core/edr_in_if.sv =====
// ============================================================================
// Edit distance input channel
// Valid/ready channel carrying one operation word.
// ============================================================================
interface edr_in_if;

    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink   (input valid, input op, input ch, output ready);

endinterface

// ===== rtl/core/edr_out_if.sv =====
// ============================================================================
// Edit distance result channel
// Valid/ready channel carrying one distance result word.
// ============================================================================
interface edr_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] distance;
    logic [7:0] total_length;
    logic       error_flag;

    modport source (output valid, output distance, output total_length,
                    output error_flag, input ready);
    modport sink   (input valid, input distance, input total_length,
                    input error_flag, output ready);

endinterface

// ===== rtl/core/edr_cell.sv =====
// ============================================================================
// Edit distance cell
// Holds one second-string byte and its cost-row entry. A token from the
// left neighbor carries the new left cost and the old diagonal cost; the
// cell updates its entry and hands a token to the right in the next cycle.
// ============================================================================
module edr_cell #(
    parameter int unsigned CNT_W  = 7,
    parameter int unsigned COST_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   pos,
    input  logic [CNT_W-1:0]   len,
    input  edr_pkg::ctrl_t     ctrl,
    input  logic               ld_en,
    input  logic [CNT_W-1:0]   ld_idx,
    input  logic [7:0]         ld_ch,
    input  logic               tok_in_valid,
    input  logic               tok_in_last,
    input  logic [COST_W-1:0]  tok_in_left,
    input  logic [COST_W-1:0]  tok_in_diag,
    output logic               tok_out_valid,
    output logic               tok_out_last,
    output logic [COST_W-1:0]  tok_out_left,
    output logic [COST_W-1:0]  tok_out_diag
);
    import edr_pkg::*;

    logic [7:0]        byte_reg;
    logic [COST_W-1:0] cost_reg;
    logic              act;
    logic [COST_W-1:0] above;
    logic [COST_W-1:0] up_cost;
    logic [COST_W-1:0] left_cost;
    logic [COST_W-1:0] diag_cost;
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] sub_cost;

    // Act only on a token that has not passed the last cell
    assign act = tok_in_valid && !tok_in_last;

    // Compute the new cost of this entry
    always_comb
    begin
        sub_cost  = ctrl.sub_two ? COST_W'(2) : COST_W'(1);
        above     = ctrl.first_row ? tok_in_diag + COST_W'(1) : cost_reg;
        up_cost   = above + COST_W'(1);
        left_cost = tok_in_left + COST_W'(1);
        diag_cost = tok_in_diag + ((byte_reg == ctrl.ch) ? COST_W'(0) : sub_cost);
        best      = (up_cost < left_cost) ? up_cost : left_cost;
        if (diag_cost < best)
        begin
            best = diag_cost;
        end
    end

    // Load the second-string byte at this position
    always_ff @(posedge clk)
    begin
        if (ld_en && (ld_idx == pos - CNT_W'(1)))
        begin
            byte_reg <= ld_ch;
        end
    end

    // Hold the cost entry and the outgoing token payload
    always_ff @(posedge clk)
    begin
        if (act)
        begin
            cost_reg     <= best;
            tok_out_left <= best;
            tok_out_diag <= above;
            tok_out_last <= (pos == len);
        end
    end

    // Advance the token valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out_valid <= 1'b0;
        end
        else
        begin
            tok_out_valid <= act;
        end
    end

endmodule

// ===== rtl/core/edit_distance_row_engine_unit.sv =====
// ============================================================================
// Edit distance row engine
// Levenshtein or insert/delete distance between two byte strings over a
// chain of cells, one cell per second-string byte.
// ============================================================================
// Load and finish words are handled straight from idle; a first-string byte
// starts a row update unless the loaded second string is empty, and the
// update walks the cell chain one cell per cycle; the engine returns to idle
// in the cycle after the last cell reports.
// The result register frees the input side once the result is taken or
// while it is being taken. Load the second string before the first; bytes
// past MAX_LEN or out of order are dropped and flagged in the result.
module edit_distance_row_engine_unit #(
    parameter int unsigned MAX_LEN = edr_pkg::MAX_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    edr_in_if.sink        item,
    edr_out_if.source     result,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);
    import edr_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned COST_W = $clog2(2 * MAX_LEN + 3);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  first_cnt_reg, first_cnt_next;
    logic [CNT_W-1:0]  second_cnt_reg, second_cnt_next;
    logic              err_reg, err_next;
    logic              sub_two_reg;
    ctrl_t             ctrl_reg, ctrl_next;
    logic              inj_valid_reg, inj_valid_next;
    logic [COST_W-1:0] inj_left_reg, inj_left_next;
    logic [COST_W-1:0] inj_diag_reg, inj_diag_next;
    logic [COST_W-1:0] dist_reg, dist_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_dist_reg, out_dist_next;
    logic [OUT_W-1:0]  out_total_reg, out_total_next;
    logic              out_err_reg, out_err_next;

    logic              accept;
    logic              ld_en;
    logic              done_any;
    logic [COST_W-1:0] done_cost;
    logic [CNT_W:0]    len_sum;

    logic              tok_valid [0:MAX_LEN];
    logic              tok_last  [0:MAX_LEN];
    logic [COST_W-1:0] tok_left  [0:MAX_LEN];
    logic [COST_W-1:0] tok_diag  [0:MAX_LEN];

    // Take a word only when idle and the result slot can free up
    assign item.ready = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign ld_en      = accept && (item.op == OP_LOAD) && (first_cnt_reg == '0)
                        && (second_cnt_reg < CNT_W'(MAX_LEN));

    assign result.valid        = out_valid_reg;
    assign result.distance     = out_dist_reg;
    assign result.total_length = out_total_reg;
    assign result.error_flag   = out_err_reg;

    // Feed the first cell from the injection registers
    assign tok_valid[0] = inj_valid_reg;
    assign tok_last[0]  = 1'b0;
    assign tok_left[0]  = inj_left_reg;
    assign tok_diag[0]  = inj_diag_reg;

    // Build the cell chain
    for (genvar j = 1; j <= MAX_LEN; j++)
    begin : g_cell
        edr_cell #(
            .CNT_W  (CNT_W),
            .COST_W (COST_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .pos           (CNT_W'(j)),
            .len           (second_cnt_reg),
            .ctrl          (ctrl_reg),
            .ld_en         (ld_en),
            .ld_idx        (second_cnt_reg),
            .ld_ch         (item.ch),
            .tok_in_valid  (tok_valid[j-1]),
            .tok_in_last   (tok_last[j-1]),
            .tok_in_left   (tok_left[j-1]),
            .tok_in_diag   (tok_diag[j-1]),
            .tok_out_valid (tok_valid[j]),
            .tok_out_last  (tok_last[j]),
            .tok_out_left  (tok_left[j]),
            .tok_out_diag  (tok_diag[j])
        );
    end

    // Pick up the cost of the last active cell
    always_comb
    begin
        done_any  = 1'b0;
        done_cost = '0;
        for (int k = 1; k <= MAX_LEN; k++)
        begin
            if (tok_valid[k] && tok_last[k])
            begin
                done_any  = 1'b1;
                done_cost = done_cost | tok_left[k];
            end
        end
    end

    assign len_sum = {1'b0, first_cnt_reg} + {1'b0, second_cnt_reg};

    // Sequence the operations
    always_comb
    begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        err_next        = err_reg;
        ctrl_next       = ctrl_reg;
        inj_valid_next  = 1'b0;
        inj_left_next   = inj_left_reg;
        inj_diag_next   = inj_diag_reg;
        dist_next       = dist_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_dist_next   = out_dist_reg;
        out_total_next  = out_total_reg;
        out_err_next    = out_err_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                if (done_any)
                begin
                    dist_next  = done_cost;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                if (accept)
                begin
                    priority if (item.op == OP_LOAD)
                    begin
                        if (ld_en)
                        begin
                            second_cnt_next = second_cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (item.op == OP_STEP)
                    begin
                        if (first_cnt_reg >= CNT_W'(MAX_LEN))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            first_cnt_next = first_cnt_reg + CNT_W'(1);
                            if (second_cnt_reg == '0)
                            begin
                                dist_next = COST_W'(first_cnt_reg) + COST_W'(1);
                            end
                            else
                            begin
                                inj_valid_next      = 1'b1;
                                inj_left_next       = COST_W'(first_cnt_reg) + COST_W'(1);
                                inj_diag_next       = COST_W'(first_cnt_reg);
                                ctrl_next.first_row = (first_cnt_reg == '0);
                                ctrl_next.sub_two   = sub_two_reg;
                                ctrl_next.ch        = item.ch;
                                state_next          = ST_RUN;
                            end
                        end
                    end
                    else if (item.op == OP_FINISH)
                    begin
                        out_valid_next  = 1'b1;
                        out_dist_next   = (first_cnt_reg == '0) ? OUT_W'(second_cnt_reg)
                                                                : OUT_W'(dist_reg);
                        out_total_next  = OUT_W'(len_sum);
                        out_err_next    = err_reg;
                        first_cnt_next  = '0;
                        second_cnt_next = '0;
                        err_next        = 1'b0;
                    end
                    else
                    begin
                        // drop the unused code
                    end
                end
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            err_reg        <= 1'b0;
            sub_two_reg    <= 1'b0;
            inj_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            err_reg        <= err_next;
            inj_valid_reg  <= inj_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                sub_two_reg <= cfg_wdata;
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        ctrl_reg      <= ctrl_next;
        inj_left_reg  <= inj_left_next;
        inj_diag_reg  <= inj_diag_next;
        dist_reg      <= dist_next;
        out_dist_reg  <= out_dist_next;
        out_total_reg <= out_total_next;
        out_err_reg   <= out_err_next;
    end

    // Checks
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(item.valid && item.ready && item.op == OP_FINISH))
        else $error("result raised without a finish word");

    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !item.ready)
        else $error("input accepted during a row update");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_any |-> (state_reg == ST_RUN))
        else $error("row update finished outside a run");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_cnt_reg <= CNT_W'(MAX_LEN)) && (second_cnt_reg <= CNT_W'(MAX_LEN)))
        else $error("string length beyond limit");

endmodule
